>>> sv/uqd_pkg.sv
`timescale 1ns / 1ps
// Package for the URL query decoder: transaction payload types, result kind codes,
// special characters and the hex digit decoder. Depends on nothing.
package uqd_pkg;

    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_VAL    = 2'd1;
    localparam logic [1:0] KIND_VSTART = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [1:0] ESC_NORMAL = 2'd0;
    localparam logic [1:0] ESC_FIRST  = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_uqd_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        has_value;
        logic [15:0] pair_count;
        logic        input_done;
        logic        run_last;
    } t_uqd_out;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    // Decodes one ASCII hex digit; valid is low for any other byte.
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
            d = c - CH_DIGIT0;
            h.valid = 1'b1;
            h.value = d[3:0];
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            d = c - CH_LOWER_A + 8'd10;
            h.valid = 1'b1;
            h.value = d[3:0];
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = c - CH_UPPER_A + 8'd10;
            h.valid = 1'b1;
            h.value = d[3:0];
        end
        return h;
    endfunction

endpackage

>>> sv/url_query_decoder.sv
`timescale 1ns / 1ps
// Top level of the URL query decoder: per-byte decode logic and a four-entry result queue.
// Depends on uqd_pkg for payload types, codes and the hex digit decoder.

// The decoder takes one query byte per input transaction and turns it into zero, one or two
// result transactions (key byte, value byte, value start, pair end). The decode of a byte is
// done in the cycle it is accepted and its results go into a four-entry result queue, so a
// new byte can be accepted every cycle while earlier results wait at the output, except that
// input stall rises only when fewer than two queue entries are free. Sustained throughput is
// one byte per cycle while the output does not stall, limited only by the output side taking
// one result per cycle when bytes produce two. After the last byte, all decode state resets.
module url_query_decoder
    import uqd_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_uqd_in  i_in_data,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_uqd_out o_out_data,
    input  logic     i_out_stall
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    logic [1:0]             r_esc,     n_esc;
    logic [3:0]             r_fhex,    n_fhex;
    logic                   r_fvalid,  n_fvalid;
    logic                   r_in_val,  n_in_val;
    logic [COUNT_WIDTH-1:0] r_pairs,   n_pairs;
    logic                   r_ended,   n_ended;

    t_uqd_out               r_q [QDEPTH];
    logic [QAW-1:0]         r_head,    n_head;
    logic [QAW-1:0]         r_tail,    n_tail;
    logic [QAW:0]           r_count,   n_count;

    logic                   in_fire;
    logic                   out_fire;
    t_hex                   hex;
    logic [7:0]             esc_byte;
    t_uqd_out               res_a;
    t_uqd_out               res_b;
    logic                   val_a;
    logic                   val_b;
    t_uqd_out               push0;
    t_uqd_out               push1;
    logic [1:0]             push_n;
    logic [QAW-1:0]         tail_p1;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        if (c == {COUNT_WIDTH{1'b1}}) begin
            return c;
        end
        return c + 1'b1;
    endfunction

    function automatic logic [15:0] count_field(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+15:0] wide;
        wide = {16'b0, c};
        return wide[15:0];
    endfunction

    assign in_fire     = i_in_valid && !o_in_stall;
    assign out_fire    = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_count > (QAW+1)'(QDEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_q[r_head];

    assign hex = hex_decode(i_in_data.in_byte);

    always_comb begin
        n_esc    = r_esc;
        n_fhex   = r_fhex;
        n_fvalid = r_fvalid;
        n_in_val = r_in_val;
        n_pairs  = r_pairs;
        n_ended  = r_ended;
        res_a    = '0;
        res_b    = '0;
        val_a    = 1'b0;
        val_b    = 1'b0;
        esc_byte = hex.valid ? {r_fhex, hex.value} : {4'b0, r_fhex};

        if (!r_ended) begin
            if (r_esc == ESC_FIRST) begin
                n_fvalid = hex.valid;
                n_fhex   = hex.valid ? hex.value : 4'd0;
                n_esc    = ESC_SECOND;
            end else if (r_esc == ESC_SECOND) begin
                n_esc = ESC_NORMAL;
                if (r_fvalid && esc_byte != CH_LF) begin
                    val_a            = 1'b1;
                    res_a.kind       = r_in_val ? KIND_VAL : KIND_KEY;
                    res_a.out_byte   = esc_byte;
                    res_a.pair_count = count_field(r_pairs);
                end
                n_fvalid = 1'b0;
                n_fhex   = 4'd0;
            end else begin
                n_esc = ESC_NORMAL;
                unique case (i_in_data.in_byte) inside
                    CH_PLUS: begin
                        val_a            = 1'b1;
                        res_a.kind       = r_in_val ? KIND_VAL : KIND_KEY;
                        res_a.out_byte   = CH_SPACE;
                        res_a.pair_count = count_field(r_pairs);
                    end
                    CH_PERCENT: begin
                        n_esc = ESC_FIRST;
                    end
                    CH_EQUALS: begin
                        n_in_val         = 1'b1;
                        val_a            = 1'b1;
                        res_a.kind       = KIND_VSTART;
                        res_a.pair_count = count_field(r_pairs);
                    end
                    CH_AMP, CH_NUL: begin
                        n_pairs          = sat_inc(r_pairs);
                        val_a            = 1'b1;
                        res_a.kind       = KIND_END;
                        res_a.has_value  = r_in_val;
                        res_a.pair_count = count_field(n_pairs);
                        res_a.input_done = (i_in_data.in_byte == CH_NUL);
                        n_in_val         = 1'b0;
                        n_ended          = (i_in_data.in_byte == CH_NUL);
                    end
                    default: begin
                        val_a            = 1'b1;
                        res_a.kind       = r_in_val ? KIND_VAL : KIND_KEY;
                        res_a.out_byte   = i_in_data.in_byte;
                        res_a.pair_count = count_field(r_pairs);
                    end
                endcase
            end

            if (i_in_data.last_byte && !n_ended) begin
                val_b            = 1'b1;
                res_b.kind       = KIND_END;
                res_b.has_value  = n_in_val;
                res_b.pair_count = count_field(sat_inc(n_pairs));
                res_b.input_done = 1'b1;
            end
        end

        if (val_b) begin
            res_b.run_last = 1'b1;
        end else begin
            res_a.run_last = 1'b1;
        end

        if (i_in_data.last_byte) begin
            n_esc    = ESC_NORMAL;
            n_fhex   = 4'd0;
            n_fvalid = 1'b0;
            n_in_val = 1'b0;
            n_pairs  = '0;
            n_ended  = 1'b0;
        end
    end

    assign push0   = val_a ? res_a : res_b;
    assign push1   = res_b;
    assign push_n  = in_fire ? ({1'b0, val_a} + {1'b0, val_b}) : 2'd0;
    assign tail_p1 = r_tail + 1'b1;

    always_comb begin
        n_head  = out_fire ? r_head + 1'b1 : r_head;
        n_tail  = r_tail + QAW'(push_n);
        n_count = r_count + (QAW+1)'(push_n) - (QAW+1)'(out_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc    <= ESC_NORMAL;
            r_fhex   <= 4'd0;
            r_fvalid <= 1'b0;
            r_in_val <= 1'b0;
            r_pairs  <= '0;
            r_ended  <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
        end else begin
            if (in_fire) begin
                r_esc    <= n_esc;
                r_fhex   <= n_fhex;
                r_fvalid <= n_fvalid;
                r_in_val <= n_in_val;
                r_pairs  <= n_pairs;
                r_ended  <= n_ended;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_tail] <= push0;
        end
        if (push_n == 2'd2) begin
            r_q[tail_p1] <= push1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("Result queue count exceeds its depth.");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == $past(r_count) + (QAW+1)'($past(push_n))
                            - (QAW+1)'($past(out_fire)))
        else $error("Result queue count does not follow pushes and pops.");

    a_query_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.last_byte |=> !r_ended && r_pairs == '0 && !r_in_val
                                           && r_esc == ESC_NORMAL)
        else $error("State not returned to reset after the last byte.");

    a_done_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.input_done |-> o_out_data.kind == KIND_END
                                                 && o_out_data.run_last)
        else $error("Query end flagged on a result that is not a final pair end.");

endmodule
